>>> src/tmmq_pkg.sv
`timescale 1ns / 1ps
package tmmq_pkg;
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NO_MATCH = 3'd2;
    localparam logic [2:0] ST_TOO_BIG  = 3'd3;
    localparam logic [2:0] ST_EXCEEDS  = 3'd4;
    localparam int MaxResults = 8;

    typedef struct packed {
        logic        action;
        logic [15:0] msg_tag;
        logic [6:0]  msg_length;
        logic [6:0]  max_length;
        logic [63:0] data_in;
        logic        send_end;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] data_out;
        logic [6:0]  out_length;
        logic        run_last;
    } t_rsp;
endpackage

>>> src/tag_matched_message_queue_unit.sv
`timescale 1ns / 1ps
// Tag-matched message queue over a pool of SLOT_COUNT payload slots.
// Requests: assert start with i_req while busy is low. A send request
// carries one payload word; the first word of a send takes tag and length
// and, if the length fits and a slot is free, grabs one from the free list;
// the word with send_end links the slot at the chain tail and returns one
// result. A receive request walks the chain from the head comparing tags,
// unlinks the first match, frees its slot and returns its payload words,
// run_last on the final one (ST_EXCEEDS alone if longer than max_length).
// Results appear for one cycle with o_valid; the receiver cannot stall.
// A send word passes S_SWORD; one that takes a slot passes S_SALLOC and
// S_RESP first, and one that ends the send goes on through S_SLINK and
// S_SWAIT; the send result comes in the first cycle with busy low. A
// receive steps S_WALK and S_WCHK per walked slot (one read of the
// tag/link memories each step), S_UNLINK to unlink, then S_STREAM for the
// first payload read and each payload word. busy stays high until the
// last result is registered. Reset is synchronous, active low: free list
// links slot i to i+1, chain empty. A link initialization pass runs after
// reset with busy high. Payload, tag and length memories are not cleared.
module tag_matched_message_queue_unit
    import tmmq_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_BYTES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);
    localparam int SlotWords = (SLOT_BYTES + 7) / 8;
    localparam int SW = $clog2(SLOT_COUNT + 1);
    localparam int SI = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SlotWords + 1);
    localparam int PD = SLOT_COUNT * SlotWords;
    localparam int PA = (PD > 1) ? $clog2(PD) : 1;
    localparam int NW = (SlotWords < MaxResults) ? SlotWords : MaxResults;
    localparam logic [SW-1:0] EndMark = SW'(SLOT_COUNT);
    localparam logic [7:0] SlotBytesL = 8'((SLOT_BYTES > 255) ? 255 : SLOT_BYTES);

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_SALLOC = 4'd2,
        S_SWORD = 4'd3, S_SLINK = 4'd4, S_WALK = 4'd5, S_WCHK = 4'd6,
        S_UNLINK = 4'd7, S_STREAM = 4'd8, S_SWAIT = 4'd9, S_RESP = 4'd10;

    logic [63:0] payload_mem [PD];
    logic [15:0] tag_mem [SLOT_COUNT];
    logic [6:0]  len_mem [SLOT_COUNT];
    logic [SW-1:0] link_mem [SLOT_COUNT];

    logic [3:0] r_state;
    t_req r_req;
    logic [SW-1:0] r_head, r_tail, r_free;
    logic r_active, r_holding;
    logic [SI-1:0] r_slot;
    logic [CW-1:0] r_count;
    logic [2:0] r_err;
    logic [15:0] r_stag;
    logic [6:0] r_slen;
    logic [SW-1:0] r_idx, r_prev;
    logic [SW:0] r_steps;
    logic [15:0] rd_tag;
    logic [6:0] rd_len;
    logic [SW-1:0] rd_link;
    logic [63:0] rd_pay;
    logic [3:0] r_nw, r_k;
    logic [SI-1:0] r_ini;

    // link memory: single write port, registered read
    logic lk_we;
    logic [SI-1:0] lk_wa, lk_ra;
    logic [SW-1:0] lk_wd;
    logic tl_we;
    logic pl_we;
    logic [PA-1:0] pl_wa, pl_ra;

    always_ff @(posedge i_clk) begin
        if (lk_we) link_mem[lk_wa] <= lk_wd;
        rd_link <= link_mem[lk_ra];
        if (tl_we) begin
            tag_mem[r_slot] <= r_stag;
            len_mem[r_slot] <= r_slen;
        end
        rd_tag <= tag_mem[lk_ra];
        rd_len <= len_mem[lk_ra];
        if (pl_we) payload_mem[pl_wa] <= r_req.data_in;
        rd_pay <= payload_mem[pl_ra];
    end

    logic [6:0] n_words;
    always_comb begin
        n_words = 7'(({1'b0, rd_len} + 8'd7) >> 3);
        if (n_words == 7'd0) n_words = 7'd1;
        if (n_words > 7'(NW)) n_words = 7'(NW);
    end

    always_comb begin
        lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = r_idx[SI-1:0];
        tl_we = 1'b0; pl_we = 1'b0;
        pl_wa = PA'(r_slot) * PA'(SlotWords) + PA'(r_count);
        pl_ra = PA'(r_idx[SI-1:0]) * PA'(SlotWords) + PA'(r_k);
        case (r_state)
            S_INIT: begin
                lk_we = 1'b1; lk_wa = r_ini; lk_wd = SW'(r_ini) + SW'(1);
            end
            S_SALLOC: lk_ra = r_free[SI-1:0];
            S_SWORD: pl_we = r_holding && (r_count < CW'(SlotWords));
            S_SLINK: begin
                tl_we = r_holding;
                lk_we = r_holding; lk_wa = r_slot; lk_wd = EndMark;
            end
            S_SWAIT: begin
                // link old tail to the new slot
                lk_we = r_holding && (r_tail != EndMark) && (r_head != EndMark);
                lk_wa = r_tail[SI-1:0]; lk_wd = SW'(r_slot);
            end
            S_UNLINK: begin
                lk_we = (r_prev != EndMark); lk_wa = r_prev[SI-1:0]; lk_wd = rd_link;
            end
            S_STREAM: begin
                lk_we = (r_k == 4'd0); lk_wa = r_idx[SI-1:0]; lk_wd = r_free;
            end
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_INIT; r_ini <= '0;
            r_head <= EndMark; r_tail <= EndMark; r_free <= '0;
            r_active <= 1'b0; r_holding <= 1'b0; r_count <= '0; r_err <= ST_OK;
        end else begin
            case (r_state)
                S_INIT: begin
                    r_ini <= r_ini + SI'(1);
                    if (r_ini == SI'(SLOT_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (start) begin
                    r_req <= i_req;
                    if (i_req.action) begin
                        r_idx <= r_head; r_prev <= EndMark; r_steps <= '0;
                        r_state <= S_WALK;
                    end else if (!r_active) begin
                        r_active <= 1'b1; r_holding <= 1'b0; r_count <= '0;
                        r_err <= ST_OK; r_stag <= i_req.msg_tag;
                        r_slen <= i_req.msg_length;
                        if ({1'b0, i_req.msg_length} > SlotBytesL) begin
                            r_err <= ST_TOO_BIG; r_state <= S_SWORD;
                        end else if (r_free == EndMark) begin
                            r_err <= ST_FULL; r_state <= S_SWORD;
                        end else begin
                            r_slot <= r_free[SI-1:0]; r_holding <= 1'b1;
                            r_state <= S_SALLOC;
                        end
                    end else r_state <= S_SWORD;
                end
                S_SALLOC: r_state <= S_RESP; // wait for link read
                S_RESP: begin r_free <= rd_link; r_state <= S_SWORD; end
                S_SWORD: begin
                    if (r_holding && r_count < CW'(SlotWords)) r_count <= r_count + CW'(1);
                    r_state <= r_req.send_end ? S_SLINK : S_IDLE;
                end
                S_SLINK: r_state <= S_SWAIT;
                S_SWAIT: begin
                    if (r_holding) begin
                        if (r_head == EndMark || r_tail == EndMark) r_head <= SW'(r_slot);
                        r_tail <= SW'(r_slot);
                    end
                    o_valid <= 1'b1;
                    o_rsp.status <= r_holding ? ST_OK : r_err;
                    o_rsp.data_out <= '0;
                    o_rsp.out_length <= r_holding ? r_slen : 7'd0;
                    o_rsp.run_last <= 1'b1;
                    r_active <= 1'b0; r_holding <= 1'b0; r_count <= '0; r_err <= ST_OK;
                    r_state <= S_IDLE;
                end
                S_WALK: begin
                    if (r_idx == EndMark || r_steps == (SW+1)'(SLOT_COUNT)) begin
                        o_valid <= 1'b1;
                        o_rsp <= '{ST_NO_MATCH, 64'd0, 7'd0, 1'b1};
                        r_state <= S_IDLE;
                    end else r_state <= S_WCHK;
                end
                S_WCHK: begin
                    if (rd_tag == r_req.msg_tag) begin
                        r_k <= '0;
                        r_nw <= 4'(n_words);
                        r_state <= S_UNLINK;
                    end else begin
                        r_prev <= r_idx; r_idx <= rd_link;
                        r_steps <= r_steps + (SW+1)'(1);
                        r_state <= S_WALK;
                    end
                end
                S_UNLINK: begin
                    if (r_prev == EndMark) r_head <= rd_link;
                    if (r_tail == r_idx) r_tail <= r_prev;
                    r_state <= S_STREAM;
                end
                S_STREAM: begin
                    if (r_k == 4'd0) r_free <= r_idx;
                    if (r_req.max_length < rd_len) begin
                        o_valid <= 1'b1;
                        o_rsp <= '{ST_EXCEEDS, 64'd0, 7'd0, 1'b1};
                        r_state <= S_IDLE;
                    end else begin
                        // payload read issued last cycle for word r_k-1
                        if (r_k != 4'd0) begin
                            o_valid <= 1'b1;
                            o_rsp <= '{ST_OK, rd_pay, rd_len, (r_k == r_nw)};
                        end
                        if (r_k == r_nw) r_state <= S_IDLE;
                        else r_k <= r_k + 4'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
